// ----- rtl/ccidr_pkg.sv -----
// Shared definitions for the bulk-OUT message reassembler: sizes, codes and
// the structs passed between the controller, the buffer memory and the top level.
// No dependencies.
package ccidr_pkg;

    localparam int MAX_MESSAGE       = 512;
    localparam int PACKET_SIZE       = 64;
    localparam int HEADER_BYTES      = 10;
    localparam int MAX_PAYLOAD_LIMIT = MAX_MESSAGE - HEADER_BYTES;
    localparam int MAX_PAYLOAD_RESET = 502;

    localparam int BUF_AW = $clog2(MAX_MESSAGE);
    localparam int LEN_W  = $clog2(MAX_MESSAGE + 1);
    localparam int CNT_W  = $clog2(PACKET_SIZE + 1);

    localparam int MODE_W   = 2;
    localparam int DATA_W   = 8;
    localparam int RIDX_W   = 9;
    localparam int STAT_W   = 3;
    localparam int FLEN_W   = 10;
    localparam int PAYCFG_W = 9;
    localparam int HDR_W    = 32;

    typedef enum logic [MODE_W-1:0] {
        MODE_BYTE      = 2'd0,
        MODE_RELEASE   = 2'd1,
        MODE_READ      = 2'd2,
        MODE_BUS_RESET = 2'd3
    } ccidr_mode_t;

    typedef enum logic [STAT_W-1:0] {
        ST_NEED_MORE   = 3'd0,
        ST_FRAME_DONE  = 3'd1,
        ST_DROPPED     = 3'd2,
        ST_ERROR_RESET = 3'd3,
        ST_SHORT_RESET = 3'd4,
        ST_READ        = 3'd5
    } ccidr_status_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [DATA_W-1:0] data_byte;
        logic              packet_end;
        logic [RIDX_W-1:0] read_index;
    } ccidr_item_t;

    typedef struct packed {
        logic              we;
        logic [BUF_AW-1:0] waddr;
        logic [DATA_W-1:0] wdata;
        logic              re;
        logic [BUF_AW-1:0] raddr;
    } ccidr_mem_req_t;

    typedef struct packed {
        logic              emit;
        ccidr_status_t     status;
        logic [FLEN_W-1:0] frame_length;
        logic              frame_pending;
        logic              rd_sel;
    } ccidr_result_t;

endpackage

// ----- rtl/ccidr_if.sv -----
// Valid/ready channel interfaces for the reassembler's input and result items.
// Depends on ccidr_pkg for the field widths.
interface ccidr_in_if;
    logic                          valid;
    logic                          ready;
    logic [ccidr_pkg::MODE_W-1:0]  mode;
    logic [ccidr_pkg::DATA_W-1:0]  data_byte;
    logic                          packet_end;
    logic [ccidr_pkg::RIDX_W-1:0]  read_index;

    modport source (output valid, output mode, output data_byte, output packet_end,
                    output read_index, input ready);
    modport sink   (input valid, input mode, input data_byte, input packet_end,
                    input read_index, output ready);
endinterface

interface ccidr_out_if;
    logic                          valid;
    logic                          ready;
    logic [ccidr_pkg::STAT_W-1:0]  status;
    logic [ccidr_pkg::FLEN_W-1:0]  frame_length;
    logic [ccidr_pkg::DATA_W-1:0]  read_data;
    logic                          frame_pending;

    modport source (output valid, output status, output frame_length, output read_data,
                    output frame_pending, input ready);
    modport sink   (input valid, input status, input frame_length, input read_data,
                    input frame_pending, output ready);
endinterface

// ----- rtl/ccidr_buf_ram.sv -----
// Assembly buffer: single-port-write, single-port-read synchronous memory
// with registered read data. Depends on ccidr_pkg.
module ccidr_buf_ram (
    input  logic                      clk,
    input  ccidr_pkg::ccidr_mem_req_t req,
    output logic [ccidr_pkg::DATA_W-1:0] q
);
    import ccidr_pkg::*;

    logic [DATA_W-1:0] mem [MAX_MESSAGE];

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
    end

    // Read data holds until the next read, so it can wait in the output stage.
    always_ff @(posedge clk)
    begin
        if (req.re)
        begin
            q <= mem[req.raddr];
        end
    end

endmodule

// ----- rtl/ccidr_ctrl.sv -----
// Reassembly controller: packet and frame bookkeeping, header length capture,
// buffer write and read requests. Depends on ccidr_pkg.
module ccidr_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          accept,
    input  ccidr_pkg::ccidr_item_t        item,
    input  logic                          cfg_we,
    input  logic [ccidr_pkg::PAYCFG_W-1:0] cfg_wdata,
    output ccidr_pkg::ccidr_mem_req_t     mem_req,
    output ccidr_pkg::ccidr_result_t      res
);
    import ccidr_pkg::*;

    logic [LEN_W-1:0]    asm_len_reg,  asm_len_next;
    logic [LEN_W-1:0]    exp_len_reg,  exp_len_next;
    logic [CNT_W-1:0]    pkt_cnt_reg,  pkt_cnt_next;
    logic                too_long_reg, too_long_next;
    logic                discard_reg,  discard_next;
    logic [HDR_W-1:0]    hdr_len_reg,  hdr_len_next;
    logic                pending_reg,  pending_next;
    logic [PAYCFG_W-1:0] max_payload_reg;

    logic [LEN_W-1:0]    pos;
    logic [LEN_W:0]      total;
    logic [LEN_W-1:0]    exp_b;
    logic                hdr_err;
    ccidr_mem_req_t      req_c;

    always_comb
    begin
        asm_len_next  = asm_len_reg;
        exp_len_next  = exp_len_reg;
        pkt_cnt_next  = pkt_cnt_reg;
        too_long_next = too_long_reg;
        discard_next  = discard_reg;
        hdr_len_next  = hdr_len_reg;
        pending_next  = pending_reg;
        req_c         = '0;
        pos           = asm_len_reg + LEN_W'(pkt_cnt_reg);
        total         = '0;
        exp_b         = exp_len_reg;
        hdr_err       = 1'b0;
        res           = '0;
        res.status    = ST_NEED_MORE;

        case (ccidr_mode_t'(item.mode))
            MODE_BYTE:
            begin
                // A packet that starts or runs while a frame is pending is dropped whole.
                discard_next = discard_reg | pending_reg;
                if (!(discard_next || too_long_reg))
                begin
                    if (pkt_cnt_reg >= CNT_W'(PACKET_SIZE))
                    begin
                        too_long_next = 1'b1;
                    end
                    else
                    begin
                        if (pos < LEN_W'(MAX_MESSAGE))
                        begin
                            req_c.we    = 1'b1;
                            req_c.waddr = pos[BUF_AW-1:0];
                            req_c.wdata = item.data_byte;
                            case (pos)
                                LEN_W'(1): hdr_len_next[7:0]   = item.data_byte;
                                LEN_W'(2): hdr_len_next[15:8]  = item.data_byte;
                                LEN_W'(3): hdr_len_next[23:16] = item.data_byte;
                                LEN_W'(4): hdr_len_next[31:24] = item.data_byte;
                                default:   hdr_len_next        = hdr_len_reg;
                            endcase
                        end
                        pkt_cnt_next = pkt_cnt_reg + CNT_W'(1);
                    end
                end

                if (item.packet_end)
                begin
                    res.emit = 1'b1;
                    total    = (LEN_W+1)'(asm_len_reg) + (LEN_W+1)'(pkt_cnt_next);
                    if (discard_next || too_long_next)
                    begin
                        res.status = ST_DROPPED;
                    end
                    else if (total > (LEN_W+1)'(MAX_MESSAGE))
                    begin
                        asm_len_next = '0;
                        exp_len_next = '0;
                        res.status   = ST_ERROR_RESET;
                    end
                    else
                    begin
                        asm_len_next = total[LEN_W-1:0];
                        if (exp_len_reg == '0 && total >= (LEN_W+1)'(HEADER_BYTES))
                        begin
                            if (hdr_len_next > HDR_W'(max_payload_reg) ||
                                hdr_len_next > HDR_W'(MAX_PAYLOAD_LIMIT))
                            begin
                                hdr_err = 1'b1;
                            end
                            else
                            begin
                                exp_b = LEN_W'(HEADER_BYTES) + hdr_len_next[LEN_W-1:0];
                            end
                        end

                        if (hdr_err || (exp_b != '0 && total > (LEN_W+1)'(exp_b)))
                        begin
                            asm_len_next = '0;
                            exp_len_next = '0;
                            res.status   = ST_ERROR_RESET;
                        end
                        else if (exp_b != '0 && total == (LEN_W+1)'(exp_b))
                        begin
                            exp_len_next = exp_b;
                            pending_next = 1'b1;
                            res.status   = ST_FRAME_DONE;
                        end
                        else if (pkt_cnt_next < CNT_W'(PACKET_SIZE))
                        begin
                            asm_len_next = '0;
                            exp_len_next = '0;
                            res.status   = ST_SHORT_RESET;
                        end
                        else
                        begin
                            exp_len_next = exp_b;
                        end
                    end
                    pkt_cnt_next  = '0;
                    too_long_next = 1'b0;
                    discard_next  = 1'b0;
                end
            end

            MODE_RELEASE:
            begin
                res.emit = 1'b1;
                if (pending_reg)
                begin
                    pending_next = 1'b0;
                    asm_len_next = '0;
                    exp_len_next = '0;
                end
            end

            MODE_READ:
            begin
                res.emit   = 1'b1;
                res.status = ST_READ;
                if (pending_reg && LEN_W'(item.read_index) < exp_len_reg)
                begin
                    req_c.re    = 1'b1;
                    req_c.raddr = BUF_AW'(item.read_index);
                    res.rd_sel  = 1'b1;
                end
            end

            MODE_BUS_RESET:
            begin
                res.emit      = 1'b1;
                pending_next  = 1'b0;
                asm_len_next  = '0;
                exp_len_next  = '0;
                pkt_cnt_next  = '0;
                too_long_next = 1'b0;
                discard_next  = 1'b0;
                hdr_len_next  = '0;
            end

            default:
            begin
                res.emit = 1'b0;
            end
        endcase

        res.frame_pending = pending_next;
        res.frame_length  = pending_next ? FLEN_W'(exp_len_next) : '0;
        mem_req           = accept ? req_c : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            asm_len_reg  <= '0;
            exp_len_reg  <= '0;
            pkt_cnt_reg  <= '0;
            too_long_reg <= 1'b0;
            discard_reg  <= 1'b0;
            hdr_len_reg  <= '0;
            pending_reg  <= 1'b0;
        end
        else if (accept)
        begin
            asm_len_reg  <= asm_len_next;
            exp_len_reg  <= exp_len_next;
            pkt_cnt_reg  <= pkt_cnt_next;
            too_long_reg <= too_long_next;
            discard_reg  <= discard_next;
            hdr_len_reg  <= hdr_len_next;
            pending_reg  <= pending_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_payload_reg <= PAYCFG_W'(MAX_PAYLOAD_RESET);
        end
        else if (cfg_we)
        begin
            max_payload_reg <= cfg_wdata;
        end
    end

endmodule

// ----- rtl/ccidr_bulk_message_reassembler_top.sv -----
// Top level of the bulk-OUT message reassembler: channel handshakes and the
// output register. Depends on ccidr_pkg, ccidr_if, ccidr_ctrl and ccidr_buf_ram.
//
// The block takes one item per clock cycle, back to back, and answers each
// item that yields a result in the cycle after it is accepted. The frame is held
// in a 512-byte buffer memory with one write and one registered read port; a
// packet byte writes it in the cycle it is accepted, and a frame read returns
// its byte through the read register straight into the output stage. The
// input is stalled only while a result waits in the output register and the
// consumer is not taking it. Buffer contents that were never written read as
// undefined; the buffer needs no clearing after reset.
module ccid_bulk_message_reassembler_top (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [ccidr_pkg::PAYCFG_W-1:0] cfg_wdata,
    ccidr_in_if.sink                       in_ch,
    ccidr_out_if.source                    out_ch
);
    import ccidr_pkg::*;

    ccidr_item_t    item;
    ccidr_mem_req_t mem_req;
    ccidr_result_t  res;
    logic [DATA_W-1:0] ram_q;
    logic           accept;

    logic              out_valid_reg;
    logic [STAT_W-1:0] status_reg;
    logic [FLEN_W-1:0] frame_length_reg;
    logic              frame_pending_reg;
    logic              rd_sel_reg;

    assign item.mode       = in_ch.mode;
    assign item.data_byte  = in_ch.data_byte;
    assign item.packet_end = in_ch.packet_end;
    assign item.read_index = in_ch.read_index;

    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign accept      = in_ch.valid && in_ch.ready;

    ccidr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .item      (item),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .mem_req   (mem_req),
        .res       (res)
    );

    ccidr_buf_ram u_buf (
        .clk (clk),
        .req (mem_req),
        .q   (ram_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= res.emit;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg        <= res.status;
            frame_length_reg  <= res.frame_length;
            frame_pending_reg <= res.frame_pending;
            rd_sel_reg        <= res.rd_sel;
        end
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.status        = status_reg;
    assign out_ch.frame_length  = frame_length_reg;
    assign out_ch.frame_pending = frame_pending_reg;
    assign out_ch.read_data     = rd_sel_reg ? ram_q : '0;

endmodule
